/* rtl/gf_region_symbol_engine_assert.svh */
// ----------------------------------------------------------------------------
// GF region symbol engine assertion macros
// Concurrent property wrappers on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GF_REGION_SYMBOL_ENGINE_ASSERT_SVH
`define GF_REGION_SYMBOL_ENGINE_ASSERT_SVH

// Same-cycle implication
`define GRSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define GRSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/grse_pkg.sv */
// ----------------------------------------------------------------------------
// grse_pkg
// Types, codes and field-reduction constants for the GF region symbol engine.
// ----------------------------------------------------------------------------
`default_nettype none

package grse_pkg;

    localparam int SYM_W     = 16;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [7:0]  GF8_POLY_LOW  = 8'h1D;
    localparam logic [15:0] GF16_POLY_LOW = 16'h002D;

    typedef enum logic [OP_W-1:0] {
        OP_MUL  = 3'd0,
        OP_MAC  = 3'd1,
        OP_DMAC = 3'd2,
        OP_XOR  = 3'd3,
        OP_FFT  = 3'd4,
        OP_IFFT = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_MODE  = 2'd0,
        CFG_COEF_FIRST  = 2'd1,
        CFG_COEF_SECOND = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic [SYM_W-1:0] sym_c;
        logic             last_in;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0] out_first;
        logic [SYM_W-1:0] out_second;
        logic             last_out;
    } t_result;

    // x^k mod p for k = 8..14 (GF(2^8), p = 0x11D)
    localparam logic [7:0] GF8_RED [0:6] = '{
        GF8_POLY_LOW, 8'h3A, 8'h74, 8'hE8, 8'hCD, 8'h87, 8'h13
    };

    // x^k mod p for k = 16..30 (GF(2^16), p = 0x1002D)
    localparam logic [15:0] GF16_RED [0:14] = '{
        GF16_POLY_LOW, 16'h005A, 16'h00B4, 16'h0168, 16'h02D0,
        16'h05A0, 16'h0B40, 16'h1680, 16'h2D00, 16'h5A00,
        16'hB400, 16'h682D, 16'hD05A, 16'hA099, 16'h411F
    };

    // Carry-less product, then fold each high bit back with its residue.
    // Operands arrive already masked to the field width.
    function automatic logic [SYM_W-1:0] gf_mul(
        input logic [SYM_W-1:0] v,
        input logic [SYM_W-1:0] c,
        input logic             wide
    );
        logic [2*SYM_W-2:0] prod;
        logic [SYM_W-1:0]   acc;
        prod = '0;
        for (int i = 0; i < SYM_W; i++) begin
            if (c[i]) begin
                prod = prod ^ ({{(SYM_W-1){1'b0}}, v} << i);
            end
        end
        if (wide) begin
            acc = prod[SYM_W-1:0];
            for (int k = 0; k < SYM_W-1; k++) begin
                if (prod[SYM_W+k]) begin
                    acc = acc ^ GF16_RED[k];
                end
            end
        end else begin
            acc = {8'h00, prod[7:0]};
            for (int k = 0; k < 7; k++) begin
                if (prod[8+k]) begin
                    acc = acc ^ {8'h00, GF8_RED[k]};
                end
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* rtl/gf_region_symbol_engine.sv */
// ----------------------------------------------------------------------------
// gf_region_symbol_engine
// Per-symbol GF(2^8)/GF(2^16) constant multiply, multiply-accumulate, XOR and
// additive-FFT butterflies, one symbol per clock while busy is low.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  item      in         start && !busy             i_item   (grse_pkg::t_item)
//  result    out        o_res_valid (one cycle)    o_res    (grse_pkg::t_result)
//  config    in         i_cfg_valid && o_cfg_ready i_cfg_index, i_cfg_data
//
//  Items pass the input register, then the field multiply network into the
//  result register. A new item is taken every cycle while busy is low.
//  busy is high in reset and the first cycle after; i_rst_n is synchronous.
//  The receiver cannot stall; every accepted item yields one result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module gf_region_symbol_engine (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire grse_pkg::t_item                    i_item,
    output logic                                    o_res_valid,
    output grse_pkg::t_result                       o_res,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [grse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [grse_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    logic                         r_live;
    logic                         r_field_mode;
    logic [grse_pkg::SYM_W-1:0]   r_coef_first;
    logic [grse_pkg::SYM_W-1:0]   r_coef_second;

    logic                         r_in_vld;
    grse_pkg::t_item              r_in;
    logic                         r_res_vld;
    grse_pkg::t_result            r_res;
    grse_pkg::t_result            n_res;

    logic [grse_pkg::SYM_W-1:0]   mask;
    logic [grse_pkg::SYM_W-1:0]   a, b, c, c1, c2;
    logic [grse_pkg::SYM_W-1:0]   mul_src;
    logic [grse_pkg::SYM_W-1:0]   prod1, prod2, diff;

    assign busy        = !r_live;
    assign o_cfg_ready = r_live;
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

    // Control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= 1'b0;
            r_field_mode  <= 1'b0;
            r_coef_first  <= '0;
            r_coef_second <= '0;
            r_in_vld      <= 1'b0;
            r_res_vld     <= 1'b0;
        end else begin
            r_live    <= 1'b1;
            r_in_vld  <= start && !busy;
            r_res_vld <= r_in_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (grse_pkg::t_cfg_idx'(i_cfg_index))
                    grse_pkg::CFG_FIELD_MODE:  r_field_mode  <= i_cfg_data[0];
                    grse_pkg::CFG_COEF_FIRST:  r_coef_first  <= i_cfg_data;
                    grse_pkg::CFG_COEF_SECOND: r_coef_second <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        r_res <= n_res;
    end

    always_comb begin
        mask = r_field_mode ? {grse_pkg::SYM_W{1'b1}} : {8'h00, 8'hFF};
        a    = r_in.sym_a & mask;
        b    = r_in.sym_b & mask;
        c    = r_in.sym_c & mask;
        c1   = r_coef_first & mask;
        c2   = r_coef_second & mask;
        diff = a ^ b;
        // The butterflies multiply y; the inverse one multiplies x^y.
        case (grse_pkg::t_op'(r_in.op))
            grse_pkg::OP_FFT:  mul_src = b;
            grse_pkg::OP_IFFT: mul_src = diff;
            default:           mul_src = a;
        endcase
        prod1 = grse_pkg::gf_mul(mul_src, c1, r_field_mode);
        prod2 = grse_pkg::gf_mul(a, c2, r_field_mode);

        n_res.out_first  = '0;
        n_res.out_second = '0;
        n_res.last_out   = r_in.last_in;
        case (grse_pkg::t_op'(r_in.op))
            grse_pkg::OP_MUL: begin
                n_res.out_first = prod1;
            end
            grse_pkg::OP_MAC: begin
                n_res.out_first = b ^ prod1;
            end
            grse_pkg::OP_DMAC: begin
                n_res.out_first  = b ^ prod1;
                n_res.out_second = c ^ prod2;
            end
            grse_pkg::OP_XOR: begin
                n_res.out_first = diff;
            end
            grse_pkg::OP_FFT: begin
                n_res.out_first  = a ^ prod1;
                n_res.out_second = b ^ a ^ prod1;
            end
            grse_pkg::OP_IFFT: begin
                n_res.out_first  = a ^ prod1;
                n_res.out_second = diff;
            end
            default: ;
        endcase
    end

`include "gf_region_symbol_engine_assert.svh"

    `GRSE_ASSERT_NOW(a_res_from_accept, o_res_valid, $past(start && !busy, 2), "result without accepted item")
    `GRSE_ASSERT_NEXT(a_accept_to_res, r_in_vld, o_res_valid, "accepted item produced no result")
    `GRSE_ASSERT_NOW(a_last_passes, o_res_valid, o_res.last_out == $past(i_item.last_in, 2), "last flag corrupted")
    `GRSE_ASSERT_NOW(a_narrow_high_zero, o_res_valid && !r_field_mode, (o_res.out_first[15:8] == 8'h00) && (o_res.out_second[15:8] == 8'h00), "high byte set in 8-bit mode")
    `GRSE_ASSERT_NEXT(a_unused_op_zero, r_in_vld && (r_in.op > grse_pkg::OP_IFFT), (o_res.out_first == '0) && (o_res.out_second == '0), "unused op gave nonzero result")

endmodule

`default_nettype wire

/* tb/sv/gf_region_symbol_engine_test.sv */
// ----------------------------------------------------------------------------
// gf_region_symbol_engine_test
// Drives symbol transactions through the GF(2^8)/GF(2^16) engine under a
// range of field modes and coefficients, predicts each result in the bench
// and compares every result strobe field by field, in order.
// ----------------------------------------------------------------------------
module gf_region_symbol_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 256;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 162;

    // Op codes and register index the package leaves unnamed
    localparam logic [grse_pkg::OP_W-1:0]      OP_SPARE_LO  = 3'd6;
    localparam logic [grse_pkg::OP_W-1:0]      OP_SPARE_HI  = 3'd7;
    localparam logic [grse_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    grse_pkg::t_item                i_item;
    logic                           o_res_valid;
    grse_pkg::t_result              o_res;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [grse_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [grse_pkg::CFG_DAT_W-1:0] i_cfg_data;

    // Bench copy of the configuration registers
    logic        field_wide;
    logic [15:0] coef_first;
    logic [15:0] coef_second;

    grse_pkg::t_result expected_symbols[$];
    int                mismatch_count;
    int                stall_cycles;
    bit                idle_on;

    gf_region_symbol_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Shift-and-reduce multiply in the selected field
    function automatic logic [15:0] gf_product(input logic [15:0] v, input logic [15:0] c,
                                               input logic wide);
        logic [15:0] acc;
        logic [15:0] mask;
        logic [15:0] poly;
        logic [15:0] shifted;
        logic        top;
        int          width;
        width   = wide ? 16 : 8;
        mask    = wide ? 16'hFFFF : 16'h00FF;
        poly    = wide ? grse_pkg::GF16_POLY_LOW : {8'h00, grse_pkg::GF8_POLY_LOW};
        acc     = '0;
        shifted = v & mask;
        for (int i = 0; i < width; i++) begin
            if (c[i]) begin
                acc = acc ^ shifted;
            end
            top     = shifted[width-1];
            shifted = (shifted << 1) & mask;
            if (top) begin
                shifted = shifted ^ poly;
            end
        end
        return acc & mask;
    endfunction

    function automatic grse_pkg::t_result predict_symbol(input grse_pkg::t_item it);
        logic [15:0]       mask;
        logic [15:0]       a;
        logic [15:0]       b;
        logic [15:0]       c;
        logic [15:0]       c1;
        logic [15:0]       c2;
        logic [15:0]       x;
        logic [15:0]       y;
        grse_pkg::t_result r;
        mask = field_wide ? 16'hFFFF : 16'h00FF;
        a    = it.sym_a & mask;
        b    = it.sym_b & mask;
        c    = it.sym_c & mask;
        c1   = coef_first & mask;
        c2   = coef_second & mask;
        x    = '0;
        y    = '0;
        case (it.op)
            grse_pkg::OP_MUL: begin
                x = gf_product(a, c1, field_wide);
            end
            grse_pkg::OP_MAC: begin
                x = b ^ gf_product(a, c1, field_wide);
            end
            grse_pkg::OP_DMAC: begin
                x = b ^ gf_product(a, c1, field_wide);
                y = c ^ gf_product(a, c2, field_wide);
            end
            grse_pkg::OP_XOR: begin
                x = a ^ b;
            end
            grse_pkg::OP_FFT: begin
                x = a ^ gf_product(b, c1, field_wide);
                y = b ^ x;
            end
            grse_pkg::OP_IFFT: begin
                y = a ^ b;
                x = a ^ gf_product(y, c1, field_wide);
            end
            default: ;
        endcase
        r.out_first  = x & mask;
        r.out_second = y & mask;
        r.last_out   = it.last_in;
        return r;
    endfunction

    function automatic grse_pkg::t_item make_item(input logic [grse_pkg::OP_W-1:0] op,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b, input logic [15:0] c,
                                                  input logic last);
        grse_pkg::t_item it;
        it.op      = op;
        it.sym_a   = a;
        it.sym_b   = b;
        it.sym_c   = c;
        it.last_in = last;
        return it;
    endfunction

    // Lean toward the field extremes now and then
    function automatic logic [15:0] rand_symbol();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 >> $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        grse_pkg::t_result want;
        if (i_rst_n && o_res_valid) begin
            if (expected_symbols.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, o_res);
                mismatch_count++;
            end else begin
                want = expected_symbols.pop_front();
                report_field("out_first", want.out_first, o_res.out_first);
                report_field("out_second", want.out_second, o_res.out_second);
                report_field("last_out", 16'(want.last_out), 16'(o_res.last_out));
            end
        end
    end

    // Count cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_symbol(input grse_pkg::t_item it);
        int gap;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        expected_symbols.push_back(predict_symbol(it));
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [grse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            grse_pkg::CFG_FIELD_MODE:  field_wide  = data[0];
            grse_pkg::CFG_COEF_FIRST:  coef_first  = data;
            grse_pkg::CFG_COEF_SECOND: coef_second = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic wide, input logic [15:0] c1, input logic [15:0] c2);
        hold_until_drained();
        // Upper bits of the mode word carry noise; only bit 0 counts
        write_reg(grse_pkg::CFG_FIELD_MODE, {15'($urandom), wide});
        write_reg(grse_pkg::CFG_COEF_FIRST, c1);
        write_reg(grse_pkg::CFG_COEF_SECOND, c2);
    endtask

    task automatic test_reset_defaults();
        idle_on = 1'b1;
        send_symbol(make_item(grse_pkg::OP_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_symbol(make_item(grse_pkg::OP_XOR, 16'h00A5, 16'hFF5A, 16'h0000, 1'b1));
        send_symbol(make_item(grse_pkg::OP_FFT, 16'h1234, 16'h5678, 16'h9ABC, 1'b0));
    endtask

    task automatic test_gf8_extremes();
        idle_on = 1'b0;
        apply_config(1'b0, 16'hABFF, 16'hCD80);
        send_symbol(make_item(grse_pkg::OP_MUL,  16'hFFFF, 16'h0000, 16'h0000, 1'b0));
        send_symbol(make_item(grse_pkg::OP_MUL,  16'h0080, 16'hFFFF, 16'hFFFF, 1'b1));
        send_symbol(make_item(grse_pkg::OP_MAC,  16'hFF80, 16'h12FF, 16'h0000, 1'b0));
        send_symbol(make_item(grse_pkg::OP_DMAC, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
        send_symbol(make_item(grse_pkg::OP_XOR,  16'hFFFF, 16'h00FF, 16'hFFFF, 1'b0));
        send_symbol(make_item(grse_pkg::OP_FFT,  16'h0000, 16'hFFFF, 16'h0000, 1'b1));
        send_symbol(make_item(grse_pkg::OP_IFFT, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    endtask

    task automatic test_gf16_extremes();
        idle_on = 1'b1;
        apply_config(1'b1, 16'hFFFF, 16'h8000);
        send_symbol(make_item(grse_pkg::OP_MUL,  16'hFFFF, 16'h0000, 16'h0000, 1'b1));
        send_symbol(make_item(grse_pkg::OP_MUL,  16'h8000, 16'hFFFF, 16'hFFFF, 1'b0));
        send_symbol(make_item(grse_pkg::OP_MAC,  16'h8000, 16'hFFFF, 16'h0000, 1'b1));
        send_symbol(make_item(grse_pkg::OP_DMAC, 16'hFFFF, 16'h0001, 16'h8000, 1'b0));
        send_symbol(make_item(grse_pkg::OP_XOR,  16'hFFFF, 16'h5A5A, 16'hFFFF, 1'b1));
        send_symbol(make_item(grse_pkg::OP_FFT,  16'hFFFF, 16'h8000, 16'h0000, 1'b0));
        send_symbol(make_item(grse_pkg::OP_IFFT, 16'h0001, 16'hFFFF, 16'h0000, 1'b1));
    endtask

    task automatic test_spare_codes();
        idle_on = 1'b1;
        hold_until_drained();
        // A write to the unmapped index must leave every register alone
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_symbol(make_item(OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_symbol(make_item(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_symbol(make_item(grse_pkg::OP_DMAC, 16'h8001, 16'h0000, 16'h0000, 1'b1));
    endtask

    task automatic test_random_stream();
        logic            wide;
        logic [15:0]     c1;
        logic [15:0]     c2;
        grse_pkg::t_item it;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wide = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            c1   = 16'($urandom);
            c2   = 16'($urandom);
            case (phase)
                0: begin c1 = 16'hFFFF; c2 = 16'h0000; end
                1: begin c1 = 16'h0000; c2 = 16'hFFFF; end
                2: begin c1 = 16'h0001; c2 = 16'h8000; end
                3: begin c1 = 16'h8000; c2 = 16'h0001; end
                default: ;
            endcase
            // Every third phase streams back to back
            idle_on = (phase % 3) != 2;
            apply_config(wide, c1, c2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = make_item(3'($urandom_range(0, 7)), rand_symbol(), rand_symbol(),
                               rand_symbol(), 1'($urandom_range(0, 1)));
                send_symbol(it);
                if (n == PHASE_ITEMS / 2) begin
                    hold_until_drained();
                end
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        field_wide     = 1'b0;
        coef_first     = '0;
        coef_second    = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        idle_on        = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_gf8_extremes();
        test_gf16_extremes();
        test_spare_codes();
        test_random_stream();

        hold_until_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/grse_pkg.sv
rtl/gf_region_symbol_engine.sv
tb/sv/gf_region_symbol_engine_test.sv
